@@ rtl/wvb_pkg.sv @@
// ----------------------------------------------------------------------------
// Welford variance bucket package
// Shared widths and function codes.
// ----------------------------------------------------------------------------
package wvb_pkg;

   localparam int COUNT_BITS_DEF = 16;
   localparam int PRICE_BITS_DEF = 32;

   localparam int SUM_W  = 48;
   localparam int SQ_W   = 64;
   localparam int MEAN_W = 48;
   localparam int M2_W   = 64;
   localparam int VAR_W  = 63;

   typedef enum logic [1:0] {
      FUNC_ADD  = 2'd0,
      FUNC_SEAL = 2'd1,
      FUNC_OPEN = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

endpackage

@@ rtl/wvb_divider.sv @@
// ----------------------------------------------------------------------------
// Serial divider
// Unsigned restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wvb_divider
   import wvb_pkg::*;
#(
   parameter int NUM_W = 64,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numer,
   input  logic [DEN_W-1:0] denom,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff, q_in;
   logic [DEN_W:0]   r_ff, r_in;
   logic [DEN_W-1:0] d_ff, d_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[DEN_W-1:0], q_ff[NUM_W-1]};
      if (start) begin
         q_in    = numer;
         r_in    = '0;
         d_in    = denom;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;

endmodule

@@ rtl/wvb_multiplier.sv @@
// ----------------------------------------------------------------------------
// Serial multiplier
// Unsigned shift-and-add product, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module wvb_multiplier
   import wvb_pkg::*;
#(
   parameter int A_W = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [A_W-1:0]   op_a,
   input  logic [A_W-1:0]   op_b,
   output logic             done,
   output logic [2*A_W-1:0] prod
);

   localparam int CNT_W = $clog2(A_W + 1);

   logic [2*A_W-1:0] acc_ff, acc_in;
   logic [2*A_W-1:0] a_ff, a_in;
   logic [A_W-1:0]   b_ff, b_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         a_in    = {{A_W{1'b0}}, op_a};
         b_in    = op_b;
         cnt_in  = CNT_W'(A_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) acc_in = acc_ff + a_ff;
         a_in   = {a_ff[2*A_W-2:0], 1'b0};
         b_in   = {1'b0, b_ff[A_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

@@ rtl/welford_variance_bucket_unit.sv @@
// ----------------------------------------------------------------------------
// Welford variance bucket unit
// Running count, mean, Welford and naive variance of one price bucket.
//
//   channel  direction  beat contents
//   req      in         func, price
//   rsp      out        sample_count, mean_value, welford_variance,
//                       naive_variance, is_sealed, dropped
//
// Each serial 64-bit divide or multiply runs one bit per cycle in the
// shared divider and multiplier.
// A sample uses one divide for the mean and two multiplies for M2 and the
// square; the report then needs three divides and one multiply.
// Seal, open, unused codes and dropped samples run only the report; with
// fewer than two samples held, the report needs no divide or multiply.
// Reset clears all statistics and the seal.
// A waiting result blocks the next beat; a finished result sits in the
// output register while rsp_ready is low.
// ----------------------------------------------------------------------------
module welford_variance_bucket_unit
   import wvb_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int PRICE_BITS = PRICE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [PRICE_BITS-1:0] req_price,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_sample_count,
   output logic [31:0]           rsp_mean_value,
   output logic [62:0]           rsp_welford_variance,
   output logic [62:0]           rsp_naive_variance,
   output logic                  rsp_is_sealed,
   output logic                  rsp_dropped
);

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b00000000001,
      ST_MDIV  = 11'b00000000010,
      ST_MUPD  = 11'b00000000100,
      ST_MUL   = 11'b00000001000,
      ST_SQ    = 11'b00000010000,
      ST_WDIV  = 11'b00000100000,
      ST_SDIV  = 11'b00001000000,
      ST_AVDIV = 11'b00010000000,
      ST_MSQ   = 11'b00100000000,
      ST_FIN   = 11'b01000000000,
      ST_OUT   = 11'b10000000000
   } state_type;

   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0]    cnt_ff, cnt_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic signed [MEAN_W-1:0] mean_ff, mean_in;
   logic [M2_W-1:0]          m2_ff, m2_in;
   logic                     seal_ff, seal_in;

   logic signed [MEAN_W-1:0] p16_ff, p16_in;
   logic signed [MEAN_W-1:0] delta_ff, delta_in;
   logic                     drop_ff, drop_in;
   logic [M2_W-1:0]          wvar_ff, wvar_in;
   logic [SQ_W-1:0]          avsq_ff, avsq_in;
   logic [SUM_W-1:0]         mmag_ff, mmag_in;

   logic [15:0] o_cnt_ff, o_cnt_in;
   logic [31:0] o_mean_ff, o_mean_in;
   logic [62:0] o_wv_ff, o_wv_in, o_nv_ff, o_nv_in;
   logic        o_seal_ff, o_seal_in, o_drop_ff, o_drop_in;
   logic        ovalid_ff, ovalid_in;

   logic         div_start, div_done;
   logic [63:0]  div_num, div_q;
   logic [31:0]  div_den;
   logic         mul_start, mul_done;
   logic [63:0]  mul_a, mul_b;
   logic [127:0] mul_p;

   logic signed [MEAN_W-1:0] p_ext;
   logic signed [SUM_W:0]    sum_wide;
   logic [SQ_W:0]            sq_wide;
   logic [M2_W:0]            m2_wide;
   logic [MEAN_W-1:0]        dmag, d2mag;
   logic [63:0]              term;
   logic [63:0]              msq;
   logic signed [MEAN_W-1:0] mean_t, delta2;
   logic [MEAN_W-1:0]        qm;
   logic signed [MEAN_W-1:0] mean_div;

   wvb_divider #(.NUM_W(64), .DEN_W(32)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num),
      .denom (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   wvb_multiplier #(.A_W(64)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .op_a  (mul_a),
      .op_b  (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   assign req_ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign p_ext     = MEAN_W'(signed'(req_price));

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      mean_in   = mean_ff;
      m2_in     = m2_ff;
      seal_in   = seal_ff;
      p16_in    = p16_ff;
      delta_in  = delta_ff;
      drop_in   = drop_ff;
      wvar_in   = wvar_ff;
      avsq_in   = avsq_ff;
      mmag_in   = mmag_ff;
      o_cnt_in  = o_cnt_ff;
      o_mean_in = o_mean_ff;
      o_wv_in   = o_wv_ff;
      o_nv_in   = o_nv_ff;
      o_seal_in = o_seal_ff;
      o_drop_in = o_drop_ff;
      ovalid_in = ovalid_ff;
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      mul_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      sum_wide  = '0;
      sq_wide   = '0;
      m2_wide   = '0;
      term      = '0;
      msq       = '0;
      dmag      = delta_ff[MEAN_W-1] ? MEAN_W'(-delta_ff) : MEAN_W'(delta_ff);
      qm        = MEAN_W'(div_q);
      mean_div  = delta_ff[MEAN_W-1] ? -signed'(qm) : signed'(qm);
      mean_t    = mean_ff;
      delta2    = p16_ff - mean_ff;
      d2mag     = delta2[MEAN_W-1] ? MEAN_W'(-delta2) : MEAN_W'(delta2);

      if (ovalid_ff && rsp_ready) ovalid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               drop_in = 1'b0;
               unique case (func_type'(req_func))
                  FUNC_ADD: begin
                     if (seal_ff || cnt_ff == CNT_MAX) begin
                        drop_in  = 1'b1;
                        state_in = ST_WDIV;
                     end else begin
                        cnt_in   = cnt_ff + 1'b1;
                        sum_wide = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(p_ext);
                        if (sum_wide > (SUM_W+1)'(SUM_MAX)) sum_in = SUM_MAX;
                        else if (sum_wide < (SUM_W+1)'(SUM_MIN)) sum_in = SUM_MIN;
                        else sum_in = SUM_W'(sum_wide);
                        p16_in   = p_ext <<< 8;
                        delta_in = (p_ext <<< 8) - mean_ff;
                        state_in = ST_MDIV;
                     end
                  end
                  FUNC_SEAL: begin
                     seal_in  = 1'b1;
                     state_in = ST_WDIV;
                  end
                  FUNC_OPEN: begin
                     cnt_in   = '0;
                     sum_in   = '0;
                     sq_in    = '0;
                     mean_in  = '0;
                     m2_in    = '0;
                     seal_in  = 1'b0;
                     state_in = ST_WDIV;
                  end
                  FUNC_NONE: state_in = ST_WDIV;
                  default:   state_in = ST_WDIV;
               endcase
            end
         end
         ST_MDIV: begin
            div_start = 1'b1;
            div_num   = 64'(dmag);
            div_den   = 32'(cnt_ff);
            state_in  = ST_MUPD;
         end
         ST_MUPD: begin
            if (div_done) begin
               mean_t  = mean_ff + mean_div;
               mean_in = mean_t;
               delta2  = p16_ff - mean_t;
               d2mag   = delta2[MEAN_W-1] ? MEAN_W'(-delta2) : MEAN_W'(delta2);
               mul_start = 1'b1;
               mul_a   = 64'(dmag);
               mul_b   = 64'(d2mag);
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               if (mul_p[127:80] != '0) term = '1;
               else term = mul_p[79:16];
               m2_wide = {1'b0, m2_ff} + {1'b0, term};
               m2_in   = m2_wide[M2_W] ? '1 : m2_wide[M2_W-1:0];
               mul_start = 1'b1;
               mul_a   = p16_ff[MEAN_W-1] ? 64'(MEAN_W'(-p16_ff) >> 8)
                                          : 64'(MEAN_W'(p16_ff) >> 8);
               mul_b   = mul_a;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (mul_done) begin
               sq_wide  = {1'b0, sq_ff} + {1'b0, mul_p[63:0]};
               sq_in    = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];
               state_in = ST_WDIV;
            end
         end
         ST_WDIV: begin
            if (cnt_ff < COUNT_BITS'(2)) begin
               state_in = ST_FIN;
            end else begin
               div_start = 1'b1;
               div_num   = m2_ff;
               div_den   = 32'(cnt_ff - 1'b1);
               state_in  = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (div_done) begin
               wvar_in   = div_q;
               div_start = 1'b1;
               div_num   = sq_ff;
               div_den   = 32'(cnt_ff);
               state_in  = ST_AVDIV;
            end
         end
         ST_AVDIV: begin
            if (div_done) begin
               avsq_in   = div_q;
               div_start = 1'b1;
               div_num   = sum_ff[SUM_W-1] ? 64'(unsigned'(-sum_ff))
                                           : 64'(unsigned'(sum_ff));
               div_den   = 32'(cnt_ff);
               state_in  = ST_MSQ;
            end
         end
         ST_MSQ: begin
            if (div_done) begin
               mmag_in   = SUM_W'(div_q);
               mul_start = 1'b1;
               mul_a     = 64'(div_q[31:0]);
               mul_b     = 64'(div_q[31:0]);
               state_in  = ST_FIN;
            end
         end
         ST_FIN: begin
            if (cnt_ff < COUNT_BITS'(2) || mul_done) begin
               msq = (mmag_ff[SUM_W-1:32] != '0) ? '1 : mul_p[63:0];
               o_cnt_in  = 16'(cnt_ff);
               o_mean_in = 32'(mean_ff / 256);
               if (cnt_ff < COUNT_BITS'(2)) begin
                  o_wv_in = '0;
                  o_nv_in = '0;
               end else begin
                  o_wv_in = wvar_ff[63] ? '1 : wvar_ff[62:0];
                  if (avsq_ff > msq)
                     o_nv_in = ((avsq_ff - msq) > 64'h7FFFFFFFFFFFFFFF) ? '1
                               : 63'(avsq_ff - msq);
                  else
                     o_nv_in = '0;
               end
               o_seal_in = seal_ff;
               o_drop_in = drop_ff;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
         mean_ff   <= '0;
         m2_ff     <= '0;
         seal_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         sum_ff    <= sum_in;
         sq_ff     <= sq_in;
         mean_ff   <= mean_in;
         m2_ff     <= m2_in;
         seal_ff   <= seal_in;
         ovalid_ff <= ovalid_in;
      end
      p16_ff    <= p16_in;
      delta_ff  <= delta_in;
      drop_ff   <= drop_in;
      wvar_ff   <= wvar_in;
      avsq_ff   <= avsq_in;
      mmag_ff   <= mmag_in;
      o_cnt_ff  <= o_cnt_in;
      o_mean_ff <= o_mean_in;
      o_wv_ff   <= o_wv_in;
      o_nv_ff   <= o_nv_in;
      o_seal_ff <= o_seal_in;
      o_drop_ff <= o_drop_in;
   end

   assign rsp_valid            = ovalid_ff;
   assign rsp_sample_count     = o_cnt_ff;
   assign rsp_mean_value       = o_mean_ff;
   assign rsp_welford_variance = o_wv_ff;
   assign rsp_naive_variance   = o_nv_ff;
   assign rsp_is_sealed        = o_seal_ff;
   assign rsp_dropped          = o_drop_ff;

   a_one_hot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("ready while busy");
   a_seal_drop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> (rsp_is_sealed || rsp_sample_count == 16'(CNT_MAX)))
      else $error("drop without cause");
   a_small_var: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sample_count < 16'd2) |-> (rsp_welford_variance == '0))
      else $error("variance below two samples");

endmodule
